@@ design/calendar_day_count_converter_unit_defines.svh @@
// Assertion macros used by the checker file of the day count converter.
`ifndef CALENDAR_DAY_COUNT_CONVERTER_UNIT_DEFINES_SVH
`define CALENDAR_DAY_COUNT_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CDCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CDCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/cdcc_pkg.sv @@
`default_nettype none

package cdcc_pkg;

  // Register stages from the input register to the result register.
  localparam int unsigned NumStages = 11;

  typedef logic [NumStages-1:0] stage_en_t;

  typedef enum logic {
    OpDateToDays = 1'b0,
    OpDaysToDate = 1'b1
  } opcode_e;

  localparam logic [22:0] EpochReset = 23'd2451545;

  // Gregorian window: 1582-10-15 to 9999-12-31 as Julian day numbers.
  localparam logic signed [25:0] JdnFirst = 26'sd2299161;
  localparam logic signed [25:0] JdnLast  = 26'sd5373484;

  localparam logic signed [26:0] CountMax = 27'sd4194303;
  localparam logic signed [26:0] CountMin = -27'sd4194304;

  // Exact reciprocals: for x below 2^N, floor(x * ceil(2^(N+L)/d) / 2^(N+L)) = floor(x/d)
  // where 2^(L-1) < d <= 2^L.
  // packed date / 60, N = 26, L = 6
  localparam logic [26:0] Recip60Date  = 27'(((64'd1 << 32) + 64'd59) / 64'd60);
  // quotient / 60, N = 21, L = 6
  localparam logic [21:0] Recip60Month = 22'(((64'd1 << 27) + 64'd59) / 64'd60);
  // year / 100, N = 15, L = 7
  localparam logic [15:0] Recip100     = 16'(((64'd1 << 22) + 64'd99) / 64'd100);
  // (4*jdn - 7468865) / 146097, N = 24, L = 18
  localparam logic [24:0] RecipCent    = 25'(((64'd1 << 42) + 64'd146096) / 64'd146097);
  // (20*c - 2442) / 7305, N = 27, L = 13
  localparam logic [27:0] RecipYear    = 28'(((64'd1 << 40) + 64'd7304) / 64'd7305);
  // (x*10000) / 306001 with the factor 10000 folded in, N = 24, L = 19
  localparam logic [38:0] RecipMonth   =
    39'((((64'd1 << 43) + 64'd306000) / 64'd306001) * 64'd10000);

  // floor(30.6001*x) equals floor(153*x/5) for x up to 64; /5 with N = 14, L = 3
  localparam logic [21:0] MonthOffsetMul = 22'(64'd153 * (((64'd1 << 17) + 64'd4) / 64'd5));

  function automatic logic [10:0] month_offset(input logic [6:0] x);
    logic [28:0] prod;
    prod = 29'(x) * 29'(MonthOffsetMul);
    return prod[27:17];
  endfunction

endpackage

`default_nettype wire

@@ design/calendar_day_count_converter_unit.sv @@
// Channel  Dir  Handshake                  Payload
// in       in   in_valid_i / in_stall_o    opcode_i, packed_date_i, day_count_in_i
// out      out  out_valid_o / out_stall_i  day_count_out_o, date_out_o, range_error_o
// cfg      in   cfg_we_i                   cfg_wdata_i (epoch day number)
//
// One beat is taken every clock cycle while in_stall_o is low; its result is presented
// after passing the eleven registers from the input register to the result register.
// Reset clears all stage valid flags and loads the epoch day with 2451545.
// A stalled result holds in the result register while earlier stages keep filling;
// in_stall_o rises only once every stage holds a beat.
`default_nettype none

module calendar_day_count_converter_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               opcode_i,
  input  wire logic [25:0]        packed_date_i,
  input  wire logic signed [22:0] day_count_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [22:0]      day_count_out_o,
  output logic [25:0]             date_out_o,
  output logic                    range_error_o,
  input  wire logic               cfg_we_i,
  input  wire logic [22:0]        cfg_wdata_i
);

  import cdcc_pkg::*;

  logic [22:0] epoch_q;
  stage_en_t   valid_q;
  stage_en_t   valid_d;
  stage_en_t   stage_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= EpochReset;
    end else if (cfg_we_i) begin
      epoch_q <= cfg_wdata_i;
    end
  end

  // A stage may load unless it and every stage after it are full and the output is held.
  for (genvar k = 0; k < NumStages; k++) begin : g_rdy
    assign stage_rdy[k] = ~(&valid_q[NumStages-1:k]) | ~out_stall_i;
  end

  assign valid_d = (stage_rdy & {valid_q[NumStages-2:0], in_valid_i}) | (~stage_rdy & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = ~stage_rdy[0];
  assign out_valid_o = valid_q[NumStages-1];

  cdcc_datapath u_datapath (
    .clk_i           (clk_i),
    .en_i            (stage_rdy),
    .epoch_i         (epoch_q),
    .opcode_i        (opcode_i),
    .packed_date_i   (packed_date_i),
    .day_count_in_i  (day_count_in_i),
    .day_count_out_o (day_count_out_o),
    .date_out_o      (date_out_o),
    .range_error_o   (range_error_o)
  );

endmodule

`default_nettype wire

@@ design/cdcc_datapath.sv @@
`default_nettype none

module cdcc_datapath (
  input  wire logic                clk_i,
  input  wire cdcc_pkg::stage_en_t en_i,
  input  wire logic [22:0]         epoch_i,
  input  wire logic                opcode_i,
  input  wire logic [25:0]         packed_date_i,
  input  wire logic signed [22:0]  day_count_in_i,
  output logic signed [22:0]       day_count_out_o,
  output logic [25:0]              date_out_o,
  output logic                     range_error_o
);

  import cdcc_pkg::*;

  // fw_* : date to day count, bw_* : day count to date

  // Stage 0: input register
  opcode_e            s0_op_q;
  logic [25:0]        s0_packed_q;
  logic signed [22:0] s0_days_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s0_op_q     <= opcode_e'(opcode_i);
      s0_packed_q <= packed_date_i;
      s0_days_q   <= day_count_in_i;
    end
  end

  // Stage 1: packed / 60, day count plus epoch
  logic [52:0]        s1_prod_d;
  logic signed [25:0] s1_jdn_d;
  opcode_e            s1_op_q;
  logic [20:0]        s1_fw_q1_q;
  logic [5:0]         s1_fw_daylo_q;
  logic [22:0]        s1_bw_jdn_q;
  logic               s1_bw_err_q;

  assign s1_prod_d = 53'(s0_packed_q) * 53'(Recip60Date);
  assign s1_jdn_d  = 26'(s0_days_q) + {3'b000, epoch_i};

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s1_op_q       <= s0_op_q;
      s1_fw_q1_q    <= s1_prod_d[52:32];
      s1_fw_daylo_q <= s0_packed_q[5:0];
      s1_bw_jdn_q   <= s1_jdn_d[22:0];
      s1_bw_err_q   <= (s1_jdn_d < JdnFirst) || (s1_jdn_d > JdnLast);
    end
  end

  // Stage 2: day digit, quotient / 60, 4*jdn - 7468865
  logic [42:0] s2_prod_d;
  logic [5:0]  s2_q60_d;
  logic [24:0] s2_numa_d;
  opcode_e     s2_op_q;
  logic [5:0]  s2_fw_day_q;
  logic [14:0] s2_fw_year_q;
  logic [5:0]  s2_fw_q1lo_q;
  logic [23:0] s2_bw_numa_q;
  logic [22:0] s2_bw_jdn_q;
  logic        s2_bw_err_q;

  // Digits are below 64, so modulo 64 arithmetic is enough.
  assign s2_q60_d  = s1_fw_q1_q[5:0] * 6'd60;
  assign s2_prod_d = 43'(s1_fw_q1_q) * 43'(Recip60Month);
  assign s2_numa_d = {s1_bw_jdn_q, 2'b00} - 25'd7468865;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s2_op_q      <= s1_op_q;
      s2_fw_day_q  <= s1_fw_daylo_q - s2_q60_d;
      s2_fw_year_q <= s2_prod_d[41:27];
      s2_fw_q1lo_q <= s1_fw_q1_q[5:0];
      s2_bw_numa_q <= s2_numa_d[23:0];
      s2_bw_jdn_q  <= s1_bw_jdn_q;
      s2_bw_err_q  <= s1_bw_err_q;
    end
  end

  // Stage 3: month digit, shift January and February, century term
  logic [5:0]         s3_y60_d;
  logic [5:0]         s3_month_d;
  logic               s3_early_d;
  logic [48:0]        s3_prod_d;
  opcode_e            s3_op_q;
  logic signed [15:0] s3_fw_y_q;
  logic [5:0]         s3_fw_m_q;
  logic [5:0]         s3_fw_day_q;
  logic [6:0]         s3_bw_a_q;
  logic [22:0]        s3_bw_jdn_q;
  logic               s3_bw_err_q;

  assign s3_y60_d   = s2_fw_year_q[5:0] * 6'd60;
  assign s3_month_d = s2_fw_q1lo_q - s3_y60_d;
  assign s3_early_d = (s3_month_d <= 6'd2);
  assign s3_prod_d  = 49'(s2_bw_numa_q) * 49'(RecipCent);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s3_op_q     <= s2_op_q;
      s3_fw_y_q   <= signed'({1'b0, s2_fw_year_q}) - (s3_early_d ? 16'sd1 : 16'sd0);
      s3_fw_m_q   <= s3_early_d ? (s3_month_d + 6'd12) : s3_month_d;
      s3_fw_day_q <= s2_fw_day_q;
      s3_bw_a_q   <= s3_prod_d[48:42];
      s3_bw_jdn_q <= s2_bw_jdn_q;
      s3_bw_err_q <= s2_bw_err_q;
    end
  end

  // Stage 4: year / 100, c = jdn + a - a/4 + 1525
  logic [14:0]        s4_ypos_d;
  logic [30:0]        s4_prod_d;
  opcode_e            s4_op_q;
  logic [7:0]         s4_fw_cent_q;
  logic signed [15:0] s4_fw_y_q;
  logic [5:0]         s4_fw_m_q;
  logic [5:0]         s4_fw_day_q;
  logic [22:0]        s4_bw_c_q;
  logic               s4_bw_err_q;

  // Year minus one can only reach -1, whose truncated century is zero.
  assign s4_ypos_d = s3_fw_y_q[15] ? 15'd0 : s3_fw_y_q[14:0];
  assign s4_prod_d = 31'(s4_ypos_d) * 31'(Recip100);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      s4_op_q      <= s3_op_q;
      s4_fw_cent_q <= s4_prod_d[29:22];
      s4_fw_y_q    <= s3_fw_y_q;
      s4_fw_m_q    <= s3_fw_m_q;
      s4_fw_day_q  <= s3_fw_day_q;
      s4_bw_c_q    <= s3_bw_jdn_q + 23'(s3_bw_a_q) - 23'(s3_bw_a_q[6:2]) + 23'd1525;
      s4_bw_err_q  <= s3_bw_err_q;
    end
  end

  // Stage 5: Gregorian correction, days of years, days of months, 20*c - 2442
  logic [24:0]        s5_c1461_d;
  logic [27:0]        s5_numd_d;
  opcode_e            s5_op_q;
  logic signed [9:0]  s5_fw_b_q;
  logic signed [23:0] s5_fw_c0_q;
  logic [10:0]        s5_fw_d0_q;
  logic [5:0]         s5_fw_day_q;
  logic [26:0]        s5_bw_numd_q;
  logic [22:0]        s5_bw_c_q;
  logic               s5_bw_err_q;

  assign s5_c1461_d = 25'(s4_fw_y_q[14:0]) * 25'd1461;
  assign s5_numd_d  = 28'(s4_bw_c_q) * 28'd20 - 28'd2442;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      s5_op_q      <= s4_op_q;
      s5_fw_b_q    <= 10'sd2 - signed'({2'b00, s4_fw_cent_q})
                      + signed'({4'b0000, s4_fw_cent_q[7:2]});
      // 1461 * -1 / 4 truncates to -365
      s5_fw_c0_q   <= s4_fw_y_q[15] ? -24'sd365 : signed'({1'b0, s5_c1461_d[24:2]});
      s5_fw_d0_q   <= month_offset(7'(s4_fw_m_q) + 7'd1);
      s5_fw_day_q  <= s4_fw_day_q;
      s5_bw_numd_q <= s5_numd_d[26:0];
      s5_bw_c_q    <= s4_bw_c_q;
      s5_bw_err_q  <= s4_bw_err_q;
    end
  end

  // Stage 6: Julian day number, year count d
  logic [54:0]        s6_prod_d;
  opcode_e            s6_op_q;
  logic signed [25:0] s6_fw_jdn_q;
  logic [14:0]        s6_bw_d_q;
  logic [22:0]        s6_bw_c_q;
  logic               s6_bw_err_q;

  assign s6_prod_d = 55'(s5_bw_numd_q) * 55'(RecipYear);

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      s6_op_q     <= s5_op_q;
      s6_fw_jdn_q <= 26'(s5_fw_b_q) + 26'(s5_fw_c0_q) + 26'(s5_fw_d0_q)
                     + 26'(s5_fw_day_q) + 26'sd1720995;
      s6_bw_d_q   <= s6_prod_d[54:40];
      s6_bw_c_q   <= s5_bw_c_q;
      s6_bw_err_q <= s5_bw_err_q;
    end
  end

  // Stage 7: subtract epoch, days left in the year
  logic [24:0]        s7_e_d;
  logic [22:0]        s7_ce_d;
  opcode_e            s7_op_q;
  logic signed [26:0] s7_fw_diff_q;
  logic               s7_fw_err_q;
  logic [9:0]         s7_bw_ce_q;
  logic [14:0]        s7_bw_d_q;
  logic               s7_bw_err_q;

  assign s7_e_d  = 25'(s6_bw_d_q) * 25'd1461;
  assign s7_ce_d = s6_bw_c_q - s7_e_d[24:2];

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      s7_op_q      <= s6_op_q;
      s7_fw_diff_q <= 27'(s6_fw_jdn_q) - {4'b0000, epoch_i};
      s7_fw_err_q  <= (s6_fw_jdn_q < JdnFirst) || (s6_fw_jdn_q > JdnLast);
      s7_bw_ce_q   <= s7_ce_d[9:0];
      s7_bw_d_q    <= s6_bw_d_q;
      s7_bw_err_q  <= s6_bw_err_q;
    end
  end

  // Stage 8: saturate the count, month index g
  logic [48:0]        s8_prod_d;
  logic signed [22:0] s8_count_d;
  logic               s8_err_d;
  opcode_e            s8_op_q;
  logic signed [22:0] s8_fw_count_q;
  logic               s8_fw_err_q;
  logic [3:0]         s8_bw_g_q;
  logic [9:0]         s8_bw_ce_q;
  logic [14:0]        s8_bw_d_q;
  logic               s8_bw_err_q;

  assign s8_prod_d = 49'(s7_bw_ce_q) * 49'(RecipMonth);

  always_comb begin
    s8_count_d = s7_fw_diff_q[22:0];
    s8_err_d   = s7_fw_err_q;
    if (s7_fw_diff_q > CountMax) begin
      s8_count_d = CountMax[22:0];
      s8_err_d   = 1'b1;
    end else if (s7_fw_diff_q < CountMin) begin
      s8_count_d = CountMin[22:0];
      s8_err_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      s8_op_q       <= s7_op_q;
      s8_fw_count_q <= s8_count_d;
      s8_fw_err_q   <= s8_err_d;
      s8_bw_g_q     <= s8_prod_d[46:43];
      s8_bw_ce_q    <= s7_bw_ce_q;
      s8_bw_d_q     <= s7_bw_d_q;
      s8_bw_err_q   <= s7_bw_err_q;
    end
  end

  // Stage 9: day, month and year digits
  logic [9:0]         s9_day_d;
  logic [3:0]         s9_month_d;
  logic [14:0]        s9_year_d;
  opcode_e            s9_op_q;
  logic signed [22:0] s9_fw_count_q;
  logic               s9_fw_err_q;
  logic [13:0]        s9_bw_year_q;
  logic [3:0]         s9_bw_month_q;
  logic [5:0]         s9_bw_day_q;
  logic               s9_bw_err_q;

  assign s9_day_d   = s8_bw_ce_q - 10'(month_offset({3'b000, s8_bw_g_q}));
  assign s9_month_d = (s8_bw_g_q < 4'd14) ? (s8_bw_g_q - 4'd1) : (s8_bw_g_q - 4'd13);
  assign s9_year_d  = (s9_month_d > 4'd2) ? (s8_bw_d_q - 15'd4716) : (s8_bw_d_q - 15'd4715);

  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      s9_op_q       <= s8_op_q;
      s9_fw_count_q <= s8_fw_count_q;
      s9_fw_err_q   <= s8_fw_err_q;
      s9_bw_year_q  <= s9_year_d[13:0];
      s9_bw_month_q <= s9_month_d;
      s9_bw_day_q   <= s9_day_d[5:0];
      s9_bw_err_q   <= s8_bw_err_q;
    end
  end

  // Stage 10: pack the date and select the result fields
  logic [25:0]        s10_date_d;
  logic signed [22:0] s10_count_q;
  logic [25:0]        s10_date_q;
  logic               s10_err_q;

  assign s10_date_d = 26'(s9_bw_year_q) * 26'd3600 + 26'(s9_bw_month_q) * 26'd60
                      + 26'(s9_bw_day_q);

  always_ff @(posedge clk_i) begin
    if (en_i[10]) begin
      if (s9_op_q == OpDaysToDate) begin
        s10_count_q <= '0;
        s10_date_q  <= s9_bw_err_q ? 26'd0 : s10_date_d;
        s10_err_q   <= s9_bw_err_q;
      end else begin
        s10_count_q <= s9_fw_count_q;
        s10_date_q  <= '0;
        s10_err_q   <= s9_fw_err_q;
      end
    end
  end

  assign day_count_out_o = s10_count_q;
  assign date_out_o      = s10_date_q;
  assign range_error_o   = s10_err_q;

endmodule

`default_nettype wire

@@ design/cdcc_checker.sv @@
`default_nettype none
`include "calendar_day_count_converter_unit_defines.svh"

module cdcc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [22:0] day_count_out_o,
  input wire logic [25:0]        date_out_o,
  input wire logic               range_error_o
);

  // Input may only stall when the output beat is held.
  `CDCC_ASSERT_IMP(a_stall_only_when_full, in_stall_o, out_valid_o && out_stall_i, "input stalled with output free")

  // Only the field of the chosen direction carries a value.
  `CDCC_ASSERT_IMP(a_one_field_set, out_valid_o, (day_count_out_o == 23'sd0) || (date_out_o == 26'd0), "both result fields non-zero")

  // A converted date is never flagged.
  `CDCC_ASSERT_IMP(a_date_not_flagged, out_valid_o && (date_out_o != 26'd0), !range_error_o, "date given with range error")

  // Hold a stalled result beat.
  `CDCC_ASSERT_NXT(a_hold_result, out_valid_o && out_stall_i, out_valid_o && $stable(date_out_o) && $stable(day_count_out_o) && $stable(range_error_o), "stalled result changed")

endmodule

bind calendar_day_count_converter_unit cdcc_checker u_cdcc_checker (.*);

`default_nettype wire

@@ tb/calendar_day_count_converter_unit_tb.sv @@
`timescale 1ns / 100ps

module calendar_day_count_converter_unit_tb;
  import cdcc_pkg::*;

  localparam int ResetCycles   = 9;
  localparam int DrainCycles   = NumStages + 4;
  localparam int HoldCycles    = 80;
  localparam int WatchdogLimit = 2000;
  localparam logic [25:0] DateMax = 26'd35997151;

  typedef struct {
    logic signed [22:0] days;
    logic [25:0]        date;
    logic               range_err;
  } conversion_t;

  class day_count_scoreboard;
    logic [22:0] epoch_day;
    conversion_t awaited_conversions[$];
    int errors;

    function new();
      epoch_day = EpochReset;
      errors = 0;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    // Meeus date to Julian day; months 1 and 2 belong to the previous year
    function longint date_to_jdn(longint code);
      longint dd, mm, yr, y, m, a;
      dd = code % 60;
      mm = (code / 60) % 60;
      yr = code / 3600;
      if (mm <= 2) begin
        y = yr - 1;
        m = mm + 12;
      end else begin
        y = yr;
        m = mm;
      end
      a = y / 100;
      return (2 - a + a / 4) + (1461 * y) / 4 + (306001 * (m + 1)) / 10000 + dd + 1720995;
    endfunction

    function logic [25:0] jdn_to_date(longint jdn);
      longint a, b, c, d, e, g, dd, mm, yr;
      a = (4 * jdn - 7468865) / 146097;
      b = jdn + a - a / 4 + 1;
      c = b + 1524;
      d = (20 * c - 2442) / 7305;
      e = (1461 * d) / 4;
      g = ((c - e) * 10000) / 306001;
      dd = c - e - (306001 * g) / 10000;
      mm = (g < 14) ? g - 1 : g - 13;
      yr = (mm > 2) ? d - 4716 : d - 4715;
      return 26'(yr * 3600 + mm * 60 + dd);
    endfunction

    function conversion_t predict_conversion(opcode_e op, logic [25:0] pd,
                                             logic signed [22:0] dc);
      longint jdn, cnt;
      conversion_t r;
      r.days = '0;
      r.date = '0;
      r.range_err = 1'b0;
      if (op == OpDateToDays) begin
        jdn = date_to_jdn(longint'(pd));
        r.range_err = (jdn < JdnFirst) || (jdn > JdnLast);
        cnt = jdn - longint'(epoch_day);
        // saturate the count to 23 bits and flag it
        if (cnt > CountMax) begin
          cnt = CountMax;
          r.range_err = 1'b1;
        end else if (cnt < CountMin) begin
          cnt = CountMin;
          r.range_err = 1'b1;
        end
        r.days = cnt[22:0];
      end else begin
        jdn = longint'(dc) + longint'(epoch_day);
        r.range_err = (jdn < JdnFirst) || (jdn > JdnLast);
        if (!r.range_err) r.date = jdn_to_date(jdn);
      end
      return r;
    endfunction

    function void note_request(opcode_e op, logic [25:0] pd, logic signed [22:0] dc);
      awaited_conversions.push_back(predict_conversion(op, pd, dc));
    endfunction

    task check_answer(logic signed [22:0] days, logic [25:0] date, logic range_err);
      conversion_t w;
      if (awaited_conversions.size() == 0) begin
        report_mismatch($sformatf("unexpected beat days=%0d date=%0d err=%0b",
                                  days, date, range_err));
        return;
      end
      w = awaited_conversions.pop_front();
      if (days !== w.days)
        report_mismatch($sformatf("day count got %0d want %0d", days, w.days));
      if (date !== w.date)
        report_mismatch($sformatf("date got %0d want %0d", date, w.date));
      if (range_err !== w.range_err)
        report_mismatch($sformatf("range error got %0b want %0b", range_err, w.range_err));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               opcode_i = 1'b0;
  logic [25:0]        packed_date_i = '0;
  logic signed [22:0] day_count_in_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [22:0] day_count_out_o;
  logic [25:0]        date_out_o;
  logic               range_error_o;
  logic               cfg_we_i = 1'b0;
  logic [22:0]        cfg_wdata_i = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  logic [22:0] epoch_now = EpochReset;
  day_count_scoreboard sb;

  calendar_day_count_converter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .packed_date_i  (packed_date_i),
    .day_count_in_i (day_count_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .day_count_out_o(day_count_out_o),
    .date_out_o     (date_out_o),
    .range_error_o  (range_error_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_reqs != hold_done) begin
      hold_done = hold_reqs;
      hold_left = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_answer(day_count_out_o, date_out_o, range_error_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  function automatic logic [25:0] pack_date(int y, int m, int dd);
    return 26'(y * 3600 + m * 60 + dd);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_conv(opcode_e op, logic [25:0] pd, logic signed [22:0] dc);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    packed_date_i <= pd;
    day_count_in_i <= dc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(op, pd, dc);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.awaited_conversions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic start_phase(logic [22:0] e, int idle, int stall);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= e;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.epoch_day = e;
    epoch_now = e;
    idle_pct = idle;
    stall_pct = stall;
  endtask

  // Day counts either side of the Gregorian window for the current epoch
  task automatic window_edges();
    longint lo, hi;
    lo = longint'(JdnFirst) - longint'(epoch_now);
    hi = longint'(JdnLast) - longint'(epoch_now);
    send_conv(OpDaysToDate, pack_date(2000, 1, 1), 23'(lo - 1));
    send_conv(OpDaysToDate, pack_date(2000, 1, 1), 23'(lo));
    send_conv(OpDaysToDate, pack_date(2000, 1, 1), 23'(hi));
    send_conv(OpDaysToDate, pack_date(2000, 1, 1), 23'(hi + 1));
  endtask

  task automatic random_conversions(int n, int hold_at);
    opcode_e op;
    logic [25:0] pd;
    logic signed [22:0] dc;
    int r;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_reqs <= hold_reqs + 1;
      op = opcode_e'($urandom_range(1));
      r = $urandom_range(99);
      if (r < 70) begin
        pd = pack_date($urandom_range(9999, 1582), $urandom_range(12, 1),
                       $urandom_range(31, 1));
      end else if (r < 85) begin
        pd = 26'($urandom_range(DateMax));
      end else begin
        // malformed digits, kept within the field range
        pd = pack_date($urandom_range(9999), $urandom_range(59), $urandom_range(59));
        if (pd > DateMax) pd = DateMax;
      end
      if ($urandom_range(99) < 75)
        dc = 23'(longint'(JdnFirst) - longint'(epoch_now) - 50 +
                 longint'($urandom_range(JdnLast - JdnFirst + 100)));
      else
        dc = 23'($urandom);
      send_conv(op, pd, dc);
    end
  endtask

  initial begin
    sb = new();
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_conv(OpDateToDays, '0, 23'($urandom));
    send_conv(OpDateToDays, DateMax, 23'($urandom));
    send_conv(OpDateToDays, pack_date(1582, 10, 15), 23'($urandom));
    send_conv(OpDateToDays, pack_date(1582, 10, 14), 23'($urandom));
    send_conv(OpDateToDays, pack_date(2000, 1, 1), 23'($urandom));
    send_conv(OpDateToDays, pack_date(2000, 2, 29), 23'($urandom));
    send_conv(OpDateToDays, pack_date(1900, 3, 1), 23'($urandom));
    send_conv(OpDateToDays, pack_date(2024, 0, 0), 23'($urandom));
    send_conv(OpDateToDays, pack_date(2024, 59, 59), 23'($urandom));
    send_conv(OpDateToDays, pack_date(0, 1, 1), 23'($urandom));
    send_conv(OpDateToDays, pack_date(0, 2, 30), 23'($urandom));
    send_conv(OpDateToDays, pack_date(1600, 13, 5), 23'($urandom));
    send_conv(OpDateToDays, pack_date(4000, 2, 29), 23'($urandom));
    send_conv(OpDaysToDate, 26'($urandom_range(DateMax)), CountMin[22:0]);
    send_conv(OpDaysToDate, 26'($urandom_range(DateMax)), CountMax[22:0]);
    send_conv(OpDaysToDate, 26'($urandom_range(DateMax)), 23'sd0);
    send_conv(OpDaysToDate, 26'($urandom_range(DateMax)), -23'sd1);
    send_conv(OpDaysToDate, 26'($urandom_range(DateMax)), 23'sd1);
    window_edges();
    // hold the output back midway so the pipe fills and stalls the input
    random_conversions(300, 150);

    start_phase(JdnFirst[22:0], 71, 0);
    window_edges();
    random_conversions(330, -1);

    start_phase(JdnLast[22:0], 0, 71);
    window_edges();
    random_conversions(330, -1);

    start_phase(23'($urandom_range(JdnLast, JdnFirst)), 71, 71);
    window_edges();
    random_conversions(330, -1);

    start_phase(23'($urandom_range(JdnLast, JdnFirst)), 33, 33);
    window_edges();
    random_conversions(330, -1);

    settle();
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
